// ----- hdl/ist_pkg.sv -----
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants for the integer set table
// Field widths, command and status codes, and the control word sent to cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               cmp_en;
    logic               do_ins;
    logic               do_rem;
    logic [VALUE_W-1:0] key;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/ist_cell.sv -----
// ----------------------------------------------------------------------------
// ist_cell: one slot of the set table
// Holds one value, compares it with the key, and shifts or appends on command.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ist_pkg::ctrl_t              ctrl,
  input  wire logic                        prev_valid,
  input  wire logic                        next_valid,
  input  wire logic [ist_pkg::VALUE_W-1:0] next_value,
  input  wire logic                        seen_in,
  output logic                             seen_out,
  output logic                             valid,
  output logic [ist_pkg::VALUE_W-1:0]      value
);
  import ist_pkg::*;

  logic hit;

  assign seen_out = seen_in | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit <= valid && (value == ctrl.key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.do_ins && !valid && prev_valid) begin
      // first empty slot takes the new value
      valid <= 1'b1;
      value <= ctrl.key;
    end else if (ctrl.do_rem && seen_out) begin
      // close the gap: pull from the upper neighbor
      valid <= next_valid;
      value <= next_value;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ist_chain.sv -----
// ----------------------------------------------------------------------------
// ist_chain: row of table slots
// Wires the slots to their neighbors and reports whether the key was found.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_chain #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ist_pkg::ctrl_t ctrl,
  output logic                found
);
  import ist_pkg::*;

  logic [CAPACITY:0] vld;
  logic [CAPACITY:0] seen;
  logic [VALUE_W-1:0] val [CAPACITY+1];

  assign vld[CAPACITY] = 1'b0;
  assign val[CAPACITY] = '0;
  assign seen[0]       = 1'b0;
  assign found         = seen[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prv;
    if (i == 0) begin : g_head
      assign prv = 1'b1;
    end else begin : g_body
      assign prv = vld[i-1];
    end

    ist_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prv),
      .next_valid (vld[i+1]),
      .next_value (val[i+1]),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .valid      (vld[i]),
      .value      (val[i])
    );
  end

endmodule

`default_nettype wire

// ----- hdl/integer_set_table_core.sv -----
// ----------------------------------------------------------------------------
// integer_set_table_core: bounded set of distinct signed integers
// Insert, remove and membership query, entries kept in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: cmd and value.
//   Output channel (out_valid / out_stall) returns one result per request:
//   status, was_present and member_count.
//   A request goes through three steps: loading it, every slot comparing its
//   value with the key, and resolving the status while appending or
//   shifting the slots. The result is registered at the last step and then
//   shows on out_valid. The row of slots resolves the found flag and the
//   shift range by a chain through all CAPACITY slots, so one request is in
//   flight at a time, and in_stall stays high while a request is in flight.
//   The result sits in an output register; the next request is taken while
//   it waits. If the receiver is still stalling when that request reaches its
//   last step, the core holds there, and keeps the input stalled, until the
//   output register frees.
//   Reset (rst, synchronous) empties the set and drops any pending result;
//   the core comes out of reset idle and ready to accept a request.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_table_core #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ist_pkg::CMD_W-1:0]    cmd,
  input  wire logic signed [ist_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ist_pkg::STATUS_W-1:0]      status,
  output logic                              was_present,
  output logic [ist_pkg::COUNT_W-1:0]       member_count
);
  import ist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CMD_W-1:0]   req_cmd;
  logic [VALUE_W-1:0] req_value;
  logic [CW-1:0]      count, count_next;
  logic               found, full, out_free;
  logic [STATUS_W-1:0] status_next;
  logic [CW+COUNT_W-1:0] count_ext;
  ctrl_t              ctrl;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign full      = (count == CW'(CAPACITY));
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_comb begin
    ctrl.cmp_en = (state == S_CMP);
    ctrl.key    = req_value;
    ctrl.do_ins = (state == S_APPLY) && out_free && (req_cmd == CMD_INSERT)
                  && !found && !full;
    ctrl.do_rem = (state == S_APPLY) && out_free && (req_cmd == CMD_REMOVE) && found;
  end

  always_comb begin
    count_next  = count;
    status_next = found ? ST_DONE : ST_NOTFOUND;
    case (req_cmd)
      CMD_INSERT: begin
        if (found) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          count_next  = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          count_next = count - CW'(1);
        end
      end
      default: begin
        // query, and the unused code acts as a query
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_APPLY && out_free) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_cmd   <= cmd;
      req_value <= value;
    end
    if (state == S_APPLY && out_free) begin
      status       <= status_next;
      was_present  <= found;
      member_count <= count_ext[COUNT_W-1:0];
    end
  end

  ist_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .found (found)
  );

endmodule

`default_nettype wire

// ----- hdl/ist_checker.sv -----
// ----------------------------------------------------------------------------
// ist_checker: port-level checks for the integer set table
// Watches the result channel for status and count consistency and stable stalled results.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_checker #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [ist_pkg::STATUS_W-1:0]    status,
  input wire logic                            was_present,
  input wire logic [ist_pkg::COUNT_W-1:0]     member_count
);
  import ist_pkg::*;

  localparam logic [COUNT_W:0] CAP_W = (COUNT_W + 1)'(CAPACITY);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CAPACITY < 32) |-> ({1'b0, member_count} <= CAP_W))
    else $error("member_count above capacity");

  a_full_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !was_present && ({1'b0, member_count} == CAP_W
                                                         || CAPACITY > 31))
    else $error("full status with value present or count short of capacity");

  a_dup_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DUP |-> was_present)
    else $error("duplicate status without value present");

  a_notfound_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOTFOUND |-> !was_present)
    else $error("not found status with value present");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(member_count)
                               && $stable(was_present))
    else $error("stalled result changed");

endmodule

bind integer_set_table_core ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .was_present  (was_present),
  .member_count (member_count)
);

`default_nettype wire
